// ----- hw/rtl/string_escape_decoder_assert.svh -----
// Assertion macros for the string escape decoder.
`ifndef STRING_ESCAPE_DECODER_ASSERT_SVH
`define STRING_ESCAPE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SED_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("string_escape_decoder check failed");
`define SED_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("string_escape_decoder check failed");
`else
`define SED_ASSERT(lbl, clk, rst_n, prop)
`define SED_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/sed_pkg.sv -----
`timescale 1ns / 1ps

package sed_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_TEXT = 3'd0,
        PH_ESC  = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_CTRL = 3'd4,
        PH_DROP = 3'd5
    } phase_t;

    // One queued result; dbl marks the leading control one (emitted as 2 then data)
    typedef struct packed {
        logic       dbl;
        logic [7:0] data;
        logic       last;
        logic       err;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    localparam logic [7:0] CODE_CR   = 8'h0D;
    localparam logic [7:0] CODE_LF   = 8'h0A;
    localparam logic [7:0] CODE_TAB  = 8'h09;
    localparam logic [7:0] CODE_ONE  = 8'h01;
    localparam logic [7:0] CODE_LEAD = 8'h02;
    localparam logic [7:0] CODE_R    = 8'd15;
    localparam logic [7:0] CODE_P    = 8'd16;
    localparam logic [7:0] CODE_O    = 8'd17;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    // Letters A-F / a-f have low nibble 1..6
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        return is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    function automatic logic ctrl_ok(input logic [7:0] c);
        return (c == CH_R) || (c == CH_P) || (c == CH_O) || is_digit(c);
    endfunction

    function automatic logic [7:0] ctrl_code(input logic [7:0] c);
        logic [7:0] v;
        v = CODE_ONE;
        if (c == CH_R) begin
            v = CODE_R;
        end else if (c == CH_P) begin
            v = CODE_P;
        end else if (c == CH_O) begin
            v = CODE_O;
        end else begin
            case (c[3:0])
                4'd0:    v = 8'h01;
                4'd1:    v = 8'h02;
                4'd2:    v = 8'h03;
                4'd3:    v = 8'h04;
                4'd4:    v = 8'h05;
                4'd5:    v = 8'h06;
                4'd6:    v = 8'h07;
                4'd7:    v = 8'h0B;
                4'd8:    v = 8'h0C;
                4'd9:    v = 8'h0E;
                default: v = CODE_ONE;
            endcase
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/string_escape_decoder.sv -----
`timescale 1ns / 1ps
// String escape decoder.
// s_ channel: one string byte per transfer in s_tdata; a zero byte ends the string.
// m_ channel: one decoded byte per transfer in m_tdata. The transfer answering the
//   terminating zero has m_tlast high and m_tdata zero; m_tuser on it flags a
//   malformed hex or control escape seen in that string (m_tuser is 0 elsewhere).
// Escapes: \xHH, \c with 0-9/r/p/o, \r \n \t, and backslash-other gives other.
// Throughput: one input byte per cycle while the queue is not full. Bytes that
//   open an escape give no output. A leading control one is sent as two
//   transfers (2 then 1); the queue absorbs it.
// An accepted byte is written into the queue; the output register loads it from
//   the queue head when that register is empty or its current transfer is taken.
// The classifier feeds a QUEUE_DEPTH entry queue; the output stage drains it.
// When the receiver stalls, the output register holds and the queue fills;
//   s_tready drops only when the queue is full.
// Reset (aresetn low, synchronous) returns to normal text, empties the queue
//   and clears m_tvalid.
`include "string_escape_decoder_assert.svh"

module string_escape_decoder #(
    parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // end_flag
    output logic       m_tuser    // error_flag
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic               push;
    logic               pop;
    sed_pkg::op_t       push_op;
    sed_pkg::op_t       head;
    sed_pkg::q_status_t q_status;
    logic [CW-1:0]      q_count;

    sed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .push     (push),
        .push_op  (push_op)
    );

    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .status  (q_status),
        .count   (q_count)
    );

    sed_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    `SED_ASSERT(a_count_bound, aclk, aresetn, q_count <= CW'(QUEUE_DEPTH))
    `SED_ASSERT(a_err_only_on_end, aclk, aresetn, (m_tvalid && m_tuser) |-> m_tlast)
    `SED_ASSERT(a_end_queued, aclk, aresetn,
        (s_tvalid && s_tready && s_tdata == sed_pkg::CH_NUL) |=> (q_count != '0 || m_tvalid))
    `SED_ASSERT(a_no_push_when_full, aclk, aresetn, q_status.full |-> !push)

endmodule

// ----- hw/rtl/sed_front.sv -----
`timescale 1ns / 1ps

module sed_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  sed_pkg::q_status_t q_status,
    output logic               push,
    output sed_pkg::op_t       push_op
);

    sed_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      nibble_reg, nibble_next;
    logic            any_reg, any_next;
    logic            err_reg, err_next;
    logic            accept;
    logic [7:0]      c;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= sed_pkg::PH_TEXT;
            nibble_reg <= '0;
            any_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            any_reg    <= any_next;
            err_reg    <= err_next;
        end
    end

    // next state
    always_comb begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        any_next    = any_reg;
        err_next    = err_reg;
        if (accept) begin
            if (c == sed_pkg::CH_NUL) begin
                phase_next  = sed_pkg::PH_TEXT;
                nibble_next = '0;
                any_next    = 1'b0;
                err_next    = 1'b0;
            end else begin
                case (phase_reg)
                    sed_pkg::PH_ESC: begin
                        if (c == sed_pkg::CH_X) begin
                            phase_next = sed_pkg::PH_HEX1;
                        end else if (c == sed_pkg::CH_C) begin
                            phase_next = sed_pkg::PH_CTRL;
                        end else begin
                            phase_next = sed_pkg::PH_TEXT;
                            any_next   = 1'b1;
                        end
                    end
                    sed_pkg::PH_HEX1: begin
                        if (sed_pkg::is_hex(c)) begin
                            phase_next  = sed_pkg::PH_HEX2;
                            nibble_next = sed_pkg::hex_nib(c);
                        end else begin
                            phase_next = sed_pkg::PH_DROP;
                            err_next   = 1'b1;
                        end
                    end
                    sed_pkg::PH_HEX2: begin
                        if (sed_pkg::is_hex(c)) begin
                            phase_next = sed_pkg::PH_TEXT;
                            any_next   = 1'b1;
                        end else begin
                            phase_next = sed_pkg::PH_DROP;
                            err_next   = 1'b1;
                        end
                    end
                    sed_pkg::PH_CTRL: begin
                        if (sed_pkg::ctrl_ok(c)) begin
                            phase_next = sed_pkg::PH_TEXT;
                            any_next   = 1'b1;
                        end else begin
                            phase_next = sed_pkg::PH_DROP;
                            err_next   = 1'b1;
                        end
                    end
                    sed_pkg::PH_DROP: begin
                        phase_next = sed_pkg::PH_DROP;
                    end
                    default: begin
                        if (c == sed_pkg::CH_BSLASH) begin
                            phase_next = sed_pkg::PH_ESC;
                        end else begin
                            phase_next = sed_pkg::PH_TEXT;
                            any_next   = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // outputs: classify into a queued result
    always_comb begin
        logic emit;
        logic [7:0] ctrl_v;
        emit         = 1'b0;
        ctrl_v       = sed_pkg::ctrl_code(c);
        push_op.dbl  = 1'b0;
        push_op.data = c;
        push_op.last = 1'b0;
        push_op.err  = 1'b0;
        if (c == sed_pkg::CH_NUL) begin
            emit         = 1'b1;
            push_op.data = sed_pkg::CH_NUL;
            push_op.last = 1'b1;
            push_op.err  = err_reg || (phase_reg == sed_pkg::PH_HEX1) ||
                           (phase_reg == sed_pkg::PH_HEX2) ||
                           (phase_reg == sed_pkg::PH_CTRL);
        end else begin
            case (phase_reg)
                sed_pkg::PH_ESC: begin
                    emit = (c != sed_pkg::CH_X) && (c != sed_pkg::CH_C);
                    if (c == sed_pkg::CH_R) begin
                        push_op.data = sed_pkg::CODE_CR;
                    end else if (c == sed_pkg::CH_N) begin
                        push_op.data = sed_pkg::CODE_LF;
                    end else if (c == sed_pkg::CH_T) begin
                        push_op.data = sed_pkg::CODE_TAB;
                    end
                end
                sed_pkg::PH_HEX1: begin
                    emit = 1'b0;
                end
                sed_pkg::PH_HEX2: begin
                    emit         = sed_pkg::is_hex(c);
                    push_op.data = {nibble_reg, sed_pkg::hex_nib(c)};
                end
                sed_pkg::PH_CTRL: begin
                    emit         = sed_pkg::ctrl_ok(c);
                    push_op.data = ctrl_v;
                    push_op.dbl  = (ctrl_v == sed_pkg::CODE_ONE) && !any_reg;
                end
                sed_pkg::PH_DROP: begin
                    emit = 1'b0;
                end
                default: begin
                    emit = (c != sed_pkg::CH_BSLASH);
                end
            endcase
        end
        push = accept && emit;
    end

endmodule

// ----- hw/rtl/sed_queue.sv -----
`timescale 1ns / 1ps

module sed_queue #(
    parameter int DEPTH = sed_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  sed_pkg::op_t               push_op,
    input  logic                       pop,
    output sed_pkg::op_t               head,
    output sed_pkg::q_status_t         status,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sed_pkg::op_t    entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];
    assign count        = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- hw/rtl/sed_back.sv -----
`timescale 1ns / 1ps

module sed_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  sed_pkg::op_t       head,
    input  sed_pkg::q_status_t q_status,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_byte
    output logic               m_tlast,   // end_flag
    output logic               m_tuser    // error_flag
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       user_reg, user_next;
    logic       half_reg, half_next;
    logic       load;

    assign load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        half_next  = half_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !q_status.empty;
            if (!q_status.empty) begin
                if (head.dbl && !half_reg) begin
                    data_next = sed_pkg::CODE_LEAD;
                    last_next = 1'b0;
                    user_next = 1'b0;
                    half_next = 1'b1;
                end else begin
                    data_next = head.data;
                    last_next = head.last;
                    user_next = head.err;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule
